FILE: rtl/core/lru_page_replacement_core_assert.svh
// assertion macros used by the lru checker
`ifndef LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LRU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru assertion failed");

// next-cycle implication, disabled during reset
`define LRU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru assertion failed");

`endif

FILE: rtl/core/lru_pkg.sv
`timescale 1ns / 1ps

package lru_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;

  // fixed port widths
  localparam int PAGE_PORT_W = 16;
  localparam int CFG_W       = 5;
  localparam int TOTAL_W     = 32;

  // occupancy and frame count hold 0..MAX_FRAMES
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int POS_W = $clog2(MAX_FRAMES);
  localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic accept;     // transaction taken this cycle
    logic hit_any;    // reference found somewhere in the chain
    logic valid;      // cell holds a resident page
    logic in_window;  // cell position below the frame count
  } cell_ctl_t;

endpackage

FILE: rtl/core/lru_page_replacement_core.sv
`timescale 1ns / 1ps
// result: a taken transaction shows its result with done in the next cycle
// throughput: one reference per cycle, busy stays low; the receiver cannot stall
// the cycle is set by the cell chain: tag compare, hit ripple and recency shift
// reset: synchronous, empties the table, clears both totals, frame count returns to 16
module lru_page_replacement_core import lru_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [PAGE_PORT_W-1:0] page_number,
  input  logic                   cfg_write,
  input  logic [CFG_W-1:0]       cfg_data,
  output logic                   done,
  output logic                   hit,
  output logic                   evicted_valid,
  output logic [PAGE_PORT_W-1:0] evicted_page,
  output logic [TOTAL_W-1:0]     hit_total,
  output logic [TOTAL_W-1:0]     fault_total
);

  // cell i holds the page of recency rank i, most recent at cell 0
  page_t                   pages [MAX_FRAMES];
  logic [MAX_FRAMES:0]     seen;
  cell_ctl_t               ctl [MAX_FRAMES];

  cnt_t                    count;
  cnt_t                    count_next;
  cnt_t                    frames;
  cnt_t                    frames_next;
  page_t                   ref_page;
  logic                    accept;
  logic                    hit_any;
  logic                    full;
  logic [POS_W-1:0]        last_pos;
  cnt_t                    last_cnt;
  logic [CMP_W-1:0]        cfg_wide;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign ref_page = PAGE_BITS'(page_number);
  assign hit_any  = seen[MAX_FRAMES];
  assign full     = (count >= frames);
  assign last_cnt = count - cnt_t'(1);
  assign last_pos = last_cnt[POS_W-1:0];
  assign seen[0]  = 1'b0;
  assign cfg_wide = CMP_W'(cfg_data);

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign ctl[i].accept    = accept;
    assign ctl[i].hit_any   = hit_any;
    assign ctl[i].valid     = cnt_t'(i) < count;
    assign ctl[i].in_window = cnt_t'(i) < frames;

    lru_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .ref_page (ref_page),
      .nbr_page ((i == 0) ? ref_page : pages[(i == 0) ? 0 : i - 1]),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .page     (pages[i])
    );
  end

  always_comb begin
    frames_next = frames;
    count_next  = count;
    if (cfg_write) begin
      if (cfg_wide == '0) begin
        frames_next = cnt_t'(1);
      end else if (cfg_wide > CMP_W'(MAX_FRAMES)) begin
        frames_next = cnt_t'(MAX_FRAMES);
      end else begin
        frames_next = cnt_t'(cfg_wide);
      end
      // dropping the least recent pages is just a shorter stack
      if (count > frames_next) begin
        count_next = frames_next;
      end
    end else if (accept && !hit_any && !full) begin
      count_next = count + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      frames      <= cnt_t'(MAX_FRAMES);
      done        <= 1'b0;
      hit_total   <= '0;
      fault_total <= '0;
    end else begin
      count  <= count_next;
      frames <= frames_next;
      done   <= accept;
      if (accept) begin
        if (hit_any) begin
          if (hit_total != '1) begin
            hit_total <= hit_total + TOTAL_W'(1);
          end
        end else if (fault_total != '1) begin
          fault_total <= fault_total + TOTAL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit           <= hit_any;
      evicted_valid <= !hit_any && full;
      evicted_page  <= (!hit_any && full) ? PAGE_PORT_W'(pages[last_pos]) : '0;
    end
  end

endmodule

FILE: rtl/core/lru_cell.sv
`timescale 1ns / 1ps

module lru_cell import lru_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  page_t     ref_page,
  input  page_t     nbr_page,
  input  logic      seen_in,
  output logic      seen_out,
  output page_t     page
);

  logic match;
  logic load;

  assign match    = ctl.valid && (page == ref_page);
  assign seen_out = seen_in || match;

  // on a hit only positions up to the hit shift; on a miss the whole window shifts
  assign load = ctl.accept && (ctl.hit_any ? !seen_in : ctl.in_window);

  always_ff @(posedge clk) begin
    if (load) begin
      page <= nbr_page;
    end
  end

endmodule

FILE: rtl/core/lru_checker.sv
`timescale 1ns / 1ps
`include "lru_page_replacement_core_assert.svh"

module lru_checker import lru_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic                   hit,
  input logic                   evicted_valid,
  input logic [PAGE_PORT_W-1:0] evicted_page,
  input logic [TOTAL_W-1:0]     hit_total,
  input logic [TOTAL_W-1:0]     fault_total
);

  // every taken transaction yields exactly one result in the next cycle
  `LRU_ASSERT_NXT(a_result_follows, clk, rst, start && !busy, done)
  `LRU_ASSERT_NXT(a_no_spurious_result, clk, rst, !(start && !busy), !done)

  // an eviction only on a fault, and no page reported without one
  `LRU_ASSERT_IMP(a_evict_on_fault, clk, rst, done && evicted_valid, !hit)
  `LRU_ASSERT_IMP(a_no_evict_page_zero, clk, rst, done && !evicted_valid, evicted_page == '0)

  // a fault leaves the hit total untouched
  `LRU_ASSERT_IMP(a_fault_keeps_hits, clk, rst, done && !hit, $stable(hit_total))

endmodule

bind lru_page_replacement_core lru_checker u_lru_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .hit_total     (hit_total),
  .fault_total   (fault_total)
);

FILE: verif/tb_lru_page_replacement_core.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement_core;
  import lru_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_REFS    = 94;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;

  typedef struct packed {
    logic                   hit;
    logic                   evicted_valid;
    logic [PAGE_PORT_W-1:0] evicted_page;
    logic [TOTAL_W-1:0]     hit_total;
    logic [TOTAL_W-1:0]     fault_total;
  } lookup_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [PAGE_PORT_W-1:0] page_number = '0;
  logic                   cfg_write = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   done;
  logic                   hit;
  logic                   evicted_valid;
  logic [PAGE_PORT_W-1:0] evicted_page;
  logic [TOTAL_W-1:0]     hit_total;
  logic [TOTAL_W-1:0]     fault_total;

  lru_page_replacement_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page_number  (page_number),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .hit          (hit),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .hit_total    (hit_total),
    .fault_total  (fault_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // frame table mirror
  logic [PAGE_PORT_W-1:0] frame_page[MAX_FRAMES];
  logic [POS_W-1:0]       frame_age[MAX_FRAMES];
  int                     occupied;
  int                     frame_limit;
  logic [TOTAL_W-1:0]     hit_count;
  logic [TOTAL_W-1:0]     fault_count;

  logic [PAGE_PORT_W-1:0] ref_q[$];
  lookup_result_t         lookup_q[$];

  int error_count = 0;
  int eviction_count = 0;
  int reference_count = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int frame_plan[RANDOM_PHASES] = '{16, 1, 5, 20, 3, 8, 16, 2, 12, 31};

  function automatic void lru_clear();
    for (int i = 0; i < MAX_FRAMES; i++) begin
      frame_page[i] = '0;
      frame_age[i]  = '0;
    end
    occupied    = 0;
    frame_limit = MAX_FRAMES;
    hit_count   = '0;
    fault_count = '0;
  endfunction

  function automatic int effective_frames(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > MAX_FRAMES) return MAX_FRAMES;
    return int'(v);
  endfunction

  // shrinking the table keeps only the most recent pages
  function automatic void lru_resize(input logic [CFG_W-1:0] v);
    int kept;
    frame_limit = effective_frames(v);
    if (occupied > frame_limit) begin
      kept = 0;
      for (int i = 0; i < occupied; i++) begin
        if (int'(frame_age[i]) < frame_limit) begin
          frame_page[kept] = frame_page[i];
          frame_age[kept]  = frame_age[i];
          kept++;
        end
      end
      occupied = kept;
    end
  endfunction

  function automatic lookup_result_t lru_lookup(input logic [PAGE_PORT_W-1:0] pg);
    lookup_result_t r;
    int             slot;
    int             old_age;
    bit             found;
    r     = '0;
    slot  = 0;
    found = 1'b0;
    for (int i = 0; i < occupied; i++) begin
      if (!found && frame_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      old_age = frame_age[slot];
      for (int i = 0; i < occupied; i++)
        if (int'(frame_age[i]) < old_age) frame_age[i]++;
      frame_age[slot] = '0;
      if (hit_count != TOTAL_SAT) hit_count++;
    end else begin
      if (occupied >= frame_limit && occupied > 0) begin
        for (int i = 0; i < occupied; i++)
          if (int'(frame_age[i]) == occupied - 1) slot = i;
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[slot];
        for (int i = 0; i < occupied; i++)
          if (i != slot) frame_age[i]++;
      end else begin
        for (int i = 0; i < occupied; i++) frame_age[i]++;
        slot = occupied;
        occupied++;
      end
      frame_page[slot] = pg;
      frame_age[slot]  = '0;
      if (fault_count != TOTAL_SAT) fault_count++;
    end
    r.hit         = found;
    r.hit_total   = hit_count;
    r.fault_total = fault_count;
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [TOTAL_W-1:0] want,
                                        input logic [TOTAL_W-1:0] got);
    if (error_count < REPORT_LIMIT)
      $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
    error_count++;
  endfunction

  // driver: bursts of references with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(start && busy)) begin
      if (gap_left > 0 || ref_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        start       <= 1'b1;
        page_number <= ref_q.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // monitor: predicts on each accepted transaction, checks each result
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      lru_clear();
      lookup_q.delete();
      idle_cycles = 0;
    end else begin
      if (cfg_write) begin
        lru_resize(cfg_data);
        cfg_writes++;
      end
      if (start && !busy) begin
        want = lru_lookup(page_number);
        if (want.evicted_valid) eviction_count++;
        reference_count++;
        lookup_q.insert(lookup_q.size(), want);
      end
      if (done) begin
        if (lookup_q.size() == 0) begin
          flag_mismatch("result with no pending reference", '0, '1);
        end else begin
          want = lookup_q.pop_front();
          if (hit !== want.hit)
            flag_mismatch("hit", TOTAL_W'(want.hit), TOTAL_W'(hit));
          if (evicted_valid !== want.evicted_valid)
            flag_mismatch("evicted_valid", TOTAL_W'(want.evicted_valid),
                          TOTAL_W'(evicted_valid));
          if (evicted_page !== want.evicted_page)
            flag_mismatch("evicted_page", TOTAL_W'(want.evicted_page),
                          TOTAL_W'(evicted_page));
          if (hit_total !== want.hit_total)
            flag_mismatch("hit_total", want.hit_total, hit_total);
          if (fault_total !== want.fault_total)
            flag_mismatch("fault_total", want.fault_total, fault_total);
        end
      end
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic enqueue_ref(input logic [PAGE_PORT_W-1:0] pg);
    ref_q.insert(ref_q.size(), pg);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (ref_q.size() != 0 || start || lookup_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // mostly a working set the size of the table or a little larger, plus noise and extremes
  task automatic queue_random_refs(input int count, input int frames);
    logic [PAGE_PORT_W-1:0] pool[$];
    int                     pick;
    repeat (frames + $urandom_range(0, 4)) pool.insert(pool.size(), PAGE_PORT_W'($urandom()));
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) enqueue_ref(pool[$urandom_range(0, pool.size() - 1)]);
      else if (pick < 95) enqueue_ref(PAGE_PORT_W'($urandom()));
      else enqueue_ref(pick[0] ? '1 : '0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset frame count, hits on the oldest page and on a recent one
    enqueue_ref(16'h0000);
    enqueue_ref(16'hFFFF);
    enqueue_ref(16'h0000);
    enqueue_ref(16'hAAAA);
    enqueue_ref(16'h5555);
    enqueue_ref(16'hFFFF);
    enqueue_ref(16'h5555);
    wait_idle();

    // shrink below occupancy, then evict from a two-frame table
    write_frames(5'd2);
    enqueue_ref(16'hAAAA);
    enqueue_ref(16'h5555);
    enqueue_ref(16'h0000);
    wait_idle();

    // zero acts as one frame
    write_frames(5'd0);
    enqueue_ref(16'h0000);
    enqueue_ref(16'h8001);
    enqueue_ref(16'h7FFE);
    wait_idle();

    // out of range value acts as the full table
    write_frames(5'd31);
    enqueue_ref(16'h7FFE);
    enqueue_ref(16'h0001);
    enqueue_ref(16'h8000);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_frames(CFG_W'(frame_plan[p]));
      queue_random_refs(PHASE_REFS, effective_frames(CFG_W'(frame_plan[p])));
      wait_idle();
    end

    if (lookup_q.size() != 0)
      flag_mismatch("results never arrived", TOTAL_W'(lookup_q.size()), '0);

    $display("%0d page references: %0d hits, %0d faults, %0d evictions",
             reference_count, hit_count, fault_count, eviction_count);
    $display("%0d frame count writes, from zero up to the largest code", cfg_writes);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", error_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/lru_pkg.sv
rtl/core/lru_cell.sv
rtl/core/lru_page_replacement_core.sv
rtl/core/lru_checker.sv
verif/tb_lru_page_replacement_core.sv
